### rtl/bltg_pkg.sv
// Shared constants, types and register codes for the battery level trimmed mean gauge.
`default_nettype none

package bltg_pkg;

   // Block sizing
   localparam int SAMPLES_PER_RESULT = 10;
   localparam int LEVEL_STEPS        = 10;
   localparam int SAMPLE_BITS        = 12;

   // Fixed field widths
   localparam int REG_W       = 12;
   localparam int CSR_INDEX_W = 2;

   // Derived widths
   localparam int MEAN_DIVISOR = SAMPLES_PER_RESULT - 2;
   localparam int COUNT_W      = $clog2(SAMPLES_PER_RESULT);
   localparam int SUM_W        = SAMPLE_BITS + $clog2(SAMPLES_PER_RESULT);
   localparam int PROD_W       = SAMPLE_BITS + REG_W;
   localparam int CHARGE_W     = $clog2(LEVEL_STEPS + 1);
   localparam int DISPLAY_W    = $clog2((LEVEL_STEPS + 1) / 2 + 1);
   localparam int STEP_PROD_W  = REG_W + CHARGE_W;
   localparam int THR_W        = STEP_PROD_W + 1;

   typedef logic [SAMPLE_BITS-1:0]  sample_type;
   typedef logic [SAMPLE_BITS:0]    smallest_type;
   typedef logic [REG_W-1:0]        reg_type;
   typedef logic [COUNT_W-1:0]      count_type;
   typedef logic [SUM_W-1:0]        sum_type;
   typedef logic [PROD_W-1:0]       prod_type;
   typedef logic [CHARGE_W-1:0]     level_type;
   typedef logic [DISPLAY_W-1:0]    display_type;
   typedef logic [STEP_PROD_W-1:0]  step_prod_type;
   typedef logic signed [THR_W-1:0] thr_type;

   // Register indexes on the write port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REFERENCE_MV = 2'd0,
      CSR_TOP_MV       = 2'd1,
      CSR_STEP_MV      = 2'd2
   } csr_index_type;

   // Register reset values
   localparam reg_type REFERENCE_MV_RESET = reg_type'(3300);
   localparam reg_type TOP_MV_RESET       = reg_type'(2100);
   localparam reg_type STEP_MV_RESET      = reg_type'(40);

   // Accumulator constants
   localparam smallest_type SMALLEST_RESET = smallest_type'(1 << SAMPLE_BITS);
   localparam count_type    COUNT_LAST     = count_type'(SAMPLES_PER_RESULT - 1);

   // Configuration as seen by the datapath
   typedef struct packed {
      reg_type reference_mv;
      reg_type top_mv;
      reg_type step_mv;
   } cfg_type;

endpackage

`default_nettype wire

### rtl/bltg_acc.sv
// Sample accumulator with largest/smallest tracking and trimmed-sum stage register.
`default_nettype none

module bltg_acc (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  accept,
   input  bltg_pkg::sample_type sample,
   input  wire                  take,
   output logic                 last,
   output logic                 trim_valid,
   output bltg_pkg::sum_type    trim_sum
);

   bltg_pkg::count_type    count_ff;
   bltg_pkg::sum_type      sum_ff;
   bltg_pkg::sample_type   largest_ff;
   bltg_pkg::smallest_type smallest_ff;
   logic                   trim_valid_ff;
   logic                   trim_valid_in;
   bltg_pkg::sum_type      trim_ff;
   bltg_pkg::sum_type      trim_in;

   bltg_pkg::sum_type      sum_next;
   bltg_pkg::sample_type   largest_next;
   bltg_pkg::sample_type   smallest_next;
   bltg_pkg::sum_type      trim_next;
   logic                   finish;

   // Fold the incoming word into the running statistics
   always_comb begin
      largest_next  = (sample > largest_ff) ? sample : largest_ff;
      smallest_next = ({1'b0, sample} < smallest_ff) ? sample
                                                     : smallest_ff[bltg_pkg::SAMPLE_BITS-1:0];
      sum_next      = sum_ff + bltg_pkg::sum_type'(sample);
      trim_next     = sum_next - bltg_pkg::sum_type'(largest_next)
                               - bltg_pkg::sum_type'(smallest_next);
   end

   assign last   = (count_ff == bltg_pkg::COUNT_LAST);
   assign finish = accept && last;

   // Load the trimmed sum on the closing word, drop it once taken
   assign trim_valid_in = finish || (trim_valid_ff && !take);
   assign trim_in       = finish ? trim_next : trim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sum_ff        <= '0;
         largest_ff    <= '0;
         smallest_ff   <= bltg_pkg::SMALLEST_RESET;
         trim_valid_ff <= 1'b0;
      end else begin
         trim_valid_ff <= trim_valid_in;
         if (finish) begin
            count_ff    <= '0;
            sum_ff      <= '0;
            largest_ff  <= '0;
            smallest_ff <= bltg_pkg::SMALLEST_RESET;
         end else if (accept) begin
            count_ff    <= count_ff + bltg_pkg::count_type'(1);
            sum_ff      <= sum_next;
            largest_ff  <= largest_next;
            smallest_ff <= {1'b0, smallest_next};
         end
      end
   end

   always_ff @(posedge clock) begin
      trim_ff <= trim_in;
   end

   assign trim_valid = trim_valid_ff;
   assign trim_sum   = trim_ff;

endmodule

`default_nettype wire

### rtl/bltg_scale.sv
// Mean and millivolt scaling stage: divide the trimmed sum, multiply by the reference.
`default_nettype none

module bltg_scale (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   input  bltg_pkg::sum_type    trim_sum,
   input  bltg_pkg::cfg_type    cfg,
   input  wire                  down_ready,
   output logic                 take,
   output logic                 mv_valid,
   output bltg_pkg::reg_type    mv
);

   logic                 mv_valid_ff;
   logic                 mv_valid_in;
   bltg_pkg::reg_type    mv_ff;
   bltg_pkg::reg_type    mv_in;
   bltg_pkg::sample_type mean;
   bltg_pkg::prod_type   product;

   // Scale the trimmed mean to millivolts
   always_comb begin
      mean    = bltg_pkg::sample_type'(trim_sum / bltg_pkg::MEAN_DIVISOR);
      product = bltg_pkg::prod_type'(mean) * bltg_pkg::prod_type'(cfg.reference_mv);
   end

   // Advance when this stage is empty or its word moves on
   assign take        = in_valid && (!mv_valid_ff || down_ready);
   assign mv_valid_in = take || (mv_valid_ff && !down_ready);
   assign mv_in       = take ? product[bltg_pkg::PROD_W-1:bltg_pkg::SAMPLE_BITS] : mv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_valid_ff <= 1'b0;
      end else begin
         mv_valid_ff <= mv_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mv_ff <= mv_in;
   end

   assign mv_valid = mv_valid_ff;
   assign mv       = mv_ff;

endmodule

`default_nettype wire

### rtl/bltg_level.sv
// Level thresholds and result register.
`default_nettype none

module bltg_level (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   mv_valid,
   input  bltg_pkg::reg_type     mv,
   input  bltg_pkg::cfg_type     cfg,
   output logic                  ready,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output bltg_pkg::reg_type     rsp_millivolts,
   output bltg_pkg::level_type   rsp_charge_level,
   output bltg_pkg::display_type rsp_display_level
);

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   bltg_pkg::reg_type     mv_ff;
   bltg_pkg::reg_type     mv_in;
   bltg_pkg::level_type   charge_ff;
   bltg_pkg::level_type   charge_in;
   bltg_pkg::display_type display_ff;
   bltg_pkg::display_type display_in;

   bltg_pkg::thr_type     mv_s;
   bltg_pkg::level_type   level;
   logic [bltg_pkg::CHARGE_W:0] level_inc;
   logic                  load;

   // Walk thresholds from lowest to highest so the highest met one wins
   always_comb begin
      mv_s  = bltg_pkg::thr_type'(mv);
      level = '0;
      for (int i = bltg_pkg::LEVEL_STEPS; i >= 1; i--) begin
         if (mv_s >= bltg_pkg::thr_type'(cfg.top_mv)
                     - bltg_pkg::thr_type'(bltg_pkg::step_prod_type'(cfg.step_mv)
                                           * bltg_pkg::step_prod_type'(i))) begin
            level = bltg_pkg::level_type'(bltg_pkg::LEVEL_STEPS + 1 - i);
         end
      end
      level_inc = {1'b0, level} + {{bltg_pkg::CHARGE_W{1'b0}}, 1'b1};
   end

   // Hold the result while the receiver stalls
   assign ready        = !rsp_valid_ff || !rsp_stall;
   assign load         = mv_valid && ready;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   assign mv_in        = load ? mv : mv_ff;
   assign charge_in    = load ? level : charge_ff;
   assign display_in   = load ? bltg_pkg::display_type'(level_inc[bltg_pkg::CHARGE_W:1])
                              : display_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mv_ff      <= mv_in;
      charge_ff  <= charge_in;
      display_ff <= display_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_millivolts    = mv_ff;
   assign rsp_charge_level  = charge_ff;
   assign rsp_display_level = display_ff;

endmodule

`default_nettype wire

### rtl/battery_level_trimmed_mean_gauge_top.sv
// Top level of the battery level trimmed mean gauge.
//
// Usage:
//   Raw converter samples enter on the req_ channel (req_valid, req_stall,
//   req_sample). Every tenth accepted word closes a group: the largest and
//   smallest samples are dropped, the rest averaged, scaled by reference_mv
//   and shifted down by the sample width, and the voltage, charge level and
//   display level leave as one word on the rsp_ channel. Other words give
//   no result.
//   Path: the trimmed sum is registered in the accumulator, then passes
//   the scale stage and the level stage before rsp_valid rises.
//   Throughput: one word per cycle while req_stall is low; the three-stage
//   pipeline takes new samples while a result waits in the output register.
//   Stall: a stalled result holds; the pipeline fills behind it, and only a
//   group-closing word is refused (req_stall) when no stage is free for it.
//   Reset: synchronous, active high; clears the accumulators and all valid
//   flags and loads reference 3300, top 2100 and step 40 mV. No clearing
//   pass is needed. The user must write registers on csr_we only while the
//   block is idle, which the block does not enforce; writes to an unused index are ignored.
`default_nettype none

module battery_level_trimmed_mean_gauge_top (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [bltg_pkg::SAMPLE_BITS-1:0]     req_sample,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [bltg_pkg::REG_W-1:0]           rsp_millivolts,
   output logic [bltg_pkg::CHARGE_W-1:0]        rsp_charge_level,
   output logic [bltg_pkg::DISPLAY_W-1:0]       rsp_display_level,
   input  wire                                  csr_we,
   input  wire  [bltg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [bltg_pkg::REG_W-1:0]           csr_wdata
);

   bltg_pkg::reg_type reference_ff;
   bltg_pkg::reg_type top_ff;
   bltg_pkg::reg_type step_ff;
   bltg_pkg::cfg_type cfg;

   logic              req_accept;
   logic              acc_last;
   logic              trim_valid;
   bltg_pkg::sum_type trim_sum;
   logic              trim_take;
   logic              mv_valid;
   bltg_pkg::reg_type mv;
   logic              level_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reference_ff <= bltg_pkg::REFERENCE_MV_RESET;
         top_ff       <= bltg_pkg::TOP_MV_RESET;
         step_ff      <= bltg_pkg::STEP_MV_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bltg_pkg::CSR_REFERENCE_MV: reference_ff <= csr_wdata;
            bltg_pkg::CSR_TOP_MV:       top_ff       <= csr_wdata;
            bltg_pkg::CSR_STEP_MV:      step_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg = '{reference_mv: reference_ff, top_mv: top_ff, step_mv: step_ff};

   // Refuse only a closing word that would overwrite an untaken trimmed sum
   assign req_stall  = acc_last && trim_valid && !trim_take;
   assign req_accept = req_valid && !req_stall;

   bltg_acc u_acc (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .sample     (req_sample),
      .take       (trim_take),
      .last       (acc_last),
      .trim_valid (trim_valid),
      .trim_sum   (trim_sum)
   );

   bltg_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (trim_valid),
      .trim_sum   (trim_sum),
      .cfg        (cfg),
      .down_ready (level_ready),
      .take       (trim_take),
      .mv_valid   (mv_valid),
      .mv         (mv)
   );

   bltg_level u_level (
      .clock             (clock),
      .reset             (reset),
      .mv_valid          (mv_valid),
      .mv                (mv),
      .cfg               (cfg),
      .ready             (level_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_millivolts    (rsp_millivolts),
      .rsp_charge_level  (rsp_charge_level),
      .rsp_display_level (rsp_display_level)
   );

   // Stalling the input is only needed for a group-closing word
   a_stall_only_on_last: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> acc_last)
      else $error("input stalled on a word that does not close a group");

   // A pending trimmed sum stays until the scale stage takes it
   a_trim_held: assert property (@(posedge clock) disable iff (reset)
      trim_valid && !trim_take |=> trim_valid)
      else $error("trimmed sum lost before it was taken");

   // A new result must come from a valid scaled voltage
   a_rsp_from_mv: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(mv_valid))
      else $error("result appeared without a scaled voltage");

   // The level never exceeds the number of steps
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_charge_level <= bltg_pkg::level_type'(bltg_pkg::LEVEL_STEPS)))
      else $error("charge level out of range");

endmodule

`default_nettype wire
